>>> rtl/cau_pkg.sv
// Package for the complex arithmetic unit: widths, mode codes, shared types.
package cau_pkg;
  localparam int DataWidthDef = 16;
  localparam int FracBitsDef  = 8;
  localparam int QueueDepth   = 4;
  localparam int QueueAw      = 2;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;
endpackage

>>> rtl/cau_front.sv
// Front end: accepts items, forms sums, differences, products and divide terms into the queue.
module cau_front import cau_pkg::*; #(
  parameter int DW = DataWidthDef,
  parameter int FB = FracBitsDef,
  parameter int NW = 2 * DW + FB + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_mode,
  input  logic signed [DW-1:0] in_a_re,
  input  logic signed [DW-1:0] in_a_im,
  input  logic signed [DW-1:0] in_b_re,
  input  logic signed [DW-1:0] in_b_im,
  output logic                 q_valid,
  output logic [1:0]           q_mode,
  output logic signed [NW-1:0] q_nre,
  output logic signed [NW-1:0] q_nim,
  output logic [2*DW:0]        q_den
);
  // stage 1: six partial products and the raw operands
  logic                   v1_r;
  logic [1:0]             m1_r;
  logic signed [2*DW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r;
  logic signed [DW-1:0]   ar_r, ai_r, br_r, bi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= in_valid;
    m1_r   <= in_mode;
    ar_r   <= in_a_re; ai_r <= in_a_im; br_r <= in_b_re; bi_r <= in_b_im;
    p_rr_r <= in_a_re * in_b_re;
    p_ii_r <= in_a_im * in_b_im;
    p_ri_r <= in_a_re * in_b_im;
    p_ir_r <= in_a_im * in_b_re;
    p_bb_r <= in_b_re * in_b_re;
    p_cc_r <= in_b_im * in_b_im;
  end

  // stage 2: combine per mode
  logic signed [NW-1:0] nre, nim;
  always_comb begin
    unique case (mode_t'(m1_r))
      MODE_ADD: begin
        nre = NW'(ar_r) + NW'(br_r);
        nim = NW'(ai_r) + NW'(bi_r);
      end
      MODE_SUB: begin
        nre = NW'(ar_r) - NW'(br_r);
        nim = NW'(ai_r) - NW'(bi_r);
      end
      MODE_MUL: begin
        nre = (NW'(p_rr_r) - NW'(p_ii_r)) >>> FB;
        nim = (NW'(p_ri_r) + NW'(p_ir_r)) >>> FB;
      end
      default: begin
        nre = (NW'(p_rr_r) + NW'(p_ii_r)) <<< FB;
        nim = (NW'(p_ir_r) - NW'(p_ri_r)) <<< FB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q_valid <= 1'b0;
    else q_valid <= v1_r;
    q_mode <= m1_r;
    q_nre  <= nre;
    q_nim  <= nim;
    q_den  <= (2*DW+1)'($unsigned(p_bb_r)) + (2*DW+1)'($unsigned(p_cc_r));
  end
endmodule

>>> rtl/cau_queue.sv
// Short FIFO between front and back end.
module cau_queue import cau_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic         rd_valid,
  output logic [W-1:0] rd_data,
  output logic [QueueAw:0] count
);
  logic [W-1:0]       mem [QueueDepth];
  logic [QueueAw-1:0] wp_r, rp_r;
  logic [QueueAw:0]   cnt_r;

  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem[rp_r];
  assign count    = cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en && rd_valid) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QueueAw+1)'(wr_en) - (QueueAw+1)'(rd_en && rd_valid);
    end
  end

  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (QueueAw+1)'(QueueDepth)) |-> !wr_en || rd_en)
    else $error("queue overrun");
endmodule

>>> rtl/cau_back.sv
// Back end: radix-2 restoring division for divide items, saturation, result register.
module cau_back import cau_pkg::*; #(
  parameter int DW = DataWidthDef,
  parameter int NW = 2 * DW + 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  logic [1:0]           q_mode,
  input  logic signed [NW-1:0] q_nre,
  input  logic signed [NW-1:0] q_nim,
  input  logic [2*DW:0]        q_den,
  output logic                 q_pop,
  output logic                 out_valid,
  output logic signed [DW-1:0] out_res_re,
  output logic signed [DW-1:0] out_res_im,
  output logic                 out_div_by_zero,
  output logic                 out_overflow
);
  localparam int CW = $clog2(NW + 1);
  localparam int DENW = 2 * DW + 1;

  typedef enum logic [1:0] { S_IDLE = 2'b01, S_DIV = 2'b10 } st_t;
  st_t st_r;

  logic [NW-1:0]   qre_r, qim_r, rre_r, rim_r;
  logic [DENW-1:0] den_r;
  logic            nre_neg_r, nim_neg_r;
  logic [CW-1:0]   cnt_r;

  // saturate a signed value into DW bits
  function automatic logic [DW:0] satf(input logic signed [NW-1:0] x);
    logic signed [NW-1:0] hi, lo;
    hi = NW'((64'sd1 <<< (DW-1)) - 1);
    lo = -hi - 1;
    if (x > hi) satf = {1'b1, hi[DW-1:0]};
    else if (x < lo) satf = {1'b1, lo[DW-1:0]};
    else satf = {1'b0, x[DW-1:0]};
  endfunction

  logic direct;
  assign direct = (st_r == S_IDLE) && q_valid &&
                  (q_mode != MODE_DIV || q_den == '0);
  assign q_pop  = (st_r == S_IDLE) && q_valid;

  // one quotient bit per cycle for both parts
  logic [NW:0] tre, tim;
  assign tre = {rre_r, qre_r[NW-1]} - {{(NW+1-DENW){1'b0}}, den_r};
  assign tim = {rim_r, qim_r[NW-1]} - {{(NW+1-DENW){1'b0}}, den_r};

  logic [NW-1:0] fre, fim;
  logic [DW:0]   sre, sim;
  always_comb begin
    fre = nre_neg_r ? -{qre_r[NW-2:0], !tre[NW]} : {qre_r[NW-2:0], !tre[NW]};
    fim = nim_neg_r ? -{qim_r[NW-2:0], !tim[NW]} : {qim_r[NW-2:0], !tim[NW]};
    if (direct) begin
      sre = (q_mode == MODE_DIV) ? '0 : satf(q_nre);
      sim = (q_mode == MODE_DIV) ? '0 : satf(q_nim);
    end else begin
      sre = satf(fre);
      sim = satf(fim);
    end
  end

  logic fin;
  assign fin = (st_r == S_DIV) && cnt_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_valid <= 1'b0;
    end else begin
      out_valid <= direct || fin;
      unique case (st_r)
        S_IDLE: if (q_pop && !direct) st_r <= S_DIV;
        S_DIV:  if (fin) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
    out_res_re      <= sre[DW-1:0];
    out_res_im      <= sim[DW-1:0];
    out_overflow    <= sre[DW] | sim[DW];
    out_div_by_zero <= direct && q_mode == MODE_DIV;
    if (st_r == S_IDLE) begin
      qre_r <= q_nre[NW-1] ? -q_nre : q_nre;
      qim_r <= q_nim[NW-1] ? -q_nim : q_nim;
      nre_neg_r <= q_nre[NW-1];
      nim_neg_r <= q_nim[NW-1];
      rre_r <= '0; rim_r <= '0;
      den_r <= q_den;
      cnt_r <= CW'(NW - 1);
    end else begin
      qre_r <= {qre_r[NW-2:0], !tre[NW]};
      qim_r <= {qim_r[NW-2:0], !tim[NW]};
      rre_r <= tre[NW] ? {rre_r[NW-2:0], qre_r[NW-1]} : tre[NW-1:0];
      rim_r <= tim[NW] ? {rim_r[NW-2:0], qim_r[NW-1]} : tim[NW-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("bad state");
  a_nopop_div: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> !q_pop) else $error("pop during divide");
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_valid && !out_div_by_zero) else $error("lost quotient");
endmodule

>>> rtl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit.
// Usage:
//  Drive in_mode and the four Q8.8 operand parts with start high; the item is
//  taken at a clock edge where busy is low. Each result appears for one cycle
//  with out_valid high; the receiver cannot stall.
// Path: add, subtract, multiply and divide by zero pass from acceptance through
//  front stage 1, the front output register, the queue and the back end's result
//  register to out_valid when the back end is free. A divide is popped from the
//  queue into the restoring divider, which forms 2*DATA_WIDTH+FRAC_BITS+2
//  quotient bits (42 at the defaults); the back end takes no new item until the
//  divide result is in its result register.
// Throughput: one item per cycle for non-divide items while busy is low; the
//  four-entry queue between front and back end absorbs bursts while a divide runs.
// busy rises when the queue would have no room for a new item beyond those already in the front.
// Reset (synchronous, rst_n low) empties pipeline, queue and divider.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DataWidthDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_mode,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_res_re,
  output logic signed [DATA_WIDTH-1:0] out_res_im,
  output logic                         out_div_by_zero,
  output logic                         out_overflow
);
  localparam int NW = 2 * DATA_WIDTH + FRAC_BITS + 2;
  localparam int QW = 2 + 2 * NW + 2 * DATA_WIDTH + 1;

  logic                 acc, f_valid, f1_r, q_pop, q_valid;
  logic [1:0]           f_mode, q_mode;
  logic signed [NW-1:0] f_nre, f_nim, q_nre, q_nim;
  logic [2*DATA_WIDTH:0] f_den, q_den;
  logic [QueueAw:0]     q_count;
  logic [QW-1:0]        q_rd;

  // two items may be in the front pipe; keep queue room for them
  assign busy = (32'(q_count) + 32'(f1_r) + 32'(f_valid)) >= QueueDepth;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) f1_r <= 1'b0;
    else f1_r <= acc;
  end

  cau_front #(.DW(DATA_WIDTH), .FB(FRAC_BITS), .NW(NW)) u_front (
    .clk, .rst_n, .in_valid(acc), .in_mode, .in_a_re, .in_a_im, .in_b_re, .in_b_im,
    .q_valid(f_valid), .q_mode(f_mode), .q_nre(f_nre), .q_nim(f_nim), .q_den(f_den)
  );

  cau_queue #(.W(QW)) u_queue (
    .clk, .rst_n, .wr_en(f_valid), .wr_data({f_mode, f_nre, f_nim, f_den}),
    .rd_en(q_pop), .rd_valid(q_valid), .rd_data(q_rd), .count(q_count)
  );
  assign {q_mode, q_nre, q_nim, q_den} = q_rd;

  cau_back #(.DW(DATA_WIDTH), .NW(NW)) u_back (
    .clk, .rst_n, .q_valid, .q_mode, .q_nre, .q_nim, .q_den, .q_pop,
    .out_valid, .out_res_re, .out_res_im, .out_div_by_zero, .out_overflow
  );
endmodule
